// ----- src/dct_pkg.sv -----
// ----------------------------------------------------------------------------
// Deadline callout timer package
// Shared types, constants and helper functions for the sorted timer queue.
// ----------------------------------------------------------------------------
package dct_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = 4;
    localparam int BUCKETS  = 8;
    localparam int BUCKET_W = 4;
    localparam int MAX_FIRE = 64;
    localparam int FIRE_W   = $clog2(MAX_FIRE + 1);
    localparam int FIDX_W   = $clog2(MAX_FIRE);

    localparam logic [19:0] MIN_LEAD_RESET = 20'd1;
    localparam logic [31:0] MAX_LEAD_RESET = 32'd50000000;

    // Item kinds.
    localparam logic [2:0] KIND_ARM_AT    = 3'd0;
    localparam logic [2:0] KIND_ARM_AFTER = 3'd1;
    localparam logic [2:0] KIND_ARM_EVERY = 3'd2;
    localparam logic [2:0] KIND_CANCEL    = 3'd3;
    localparam logic [2:0] KIND_SERVICE   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_LEAD = 2'd0;
    localparam logic [1:0] REG_MAX_LEAD = 2'd1;

    // Operations broadcast to the cell row.
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    localparam logic [9:0] BOUND [BUCKETS] =
        '{10'd1, 10'd2, 10'd5, 10'd10, 10'd20, 10'd50, 10'd100, 10'd1000};

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [63:0]       deadline;
        logic [63:0]       period;
    } entry_t;

    typedef struct packed {
        logic [1:0] code;
        entry_t     ent;
    } cell_op_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [63:0] now;
        logic [63:0] when;
        logic [63:0] period;
    } item_t;

    typedef struct packed {
        logic        fired;
        logic [3:0]  fired_slot;
        logic [63:0] due_time;
        logic [63:0] next_compare;
        logic [3:0]  latency_bucket;
        logic [31:0] latency_count;
        logic        last;
    } result_t;

    // Saturating 64-bit add.
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    // Histogram bin: number of bounds that the latency exceeds.
    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [15:0] lat);
        logic [BUCKET_W-1:0] b;
        b = '0;
        for (int i = 0; i < BUCKETS; i++) begin
            if (lat > {6'd0, BOUND[i]})
            begin
                b = b + 1'b1;
            end
        end
        return b;
    endfunction

endpackage

// ----- src/dct_cell.sv -----
// ----------------------------------------------------------------------------
// Deadline callout timer queue cell
// Holds one queue entry and shifts it with its neighbors on remove, pop and insert.
// ----------------------------------------------------------------------------
module dct_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  dct_pkg::cell_op_t op,
    input  dct_pkg::entry_t  left,
    input  dct_pkg::entry_t  right,
    input  logic             keep_left,
    input  logic             hit_left,
    output dct_pkg::entry_t  ent,
    output logic             keep,
    output logic             hit
);

    logic                      valid_reg, valid_next;
    logic [dct_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [63:0]               dl_reg, dl_next;
    logic [63:0]               per_reg, per_next;
    dct_pkg::entry_t           take;
    logic                      load;

    assign ent  = '{valid: valid_reg, slot: slot_reg, deadline: dl_reg, period: per_reg};
    assign keep = valid_reg && (dl_reg <= op.ent.deadline);
    assign hit  = hit_left || (valid_reg && (slot_reg == op.ent.slot));

    // Pick the entry this cell takes for the current operation.
    always_comb
    begin
        take = ent;
        load = 1'b0;
        unique case (op.code)
            dct_pkg::OP_REMOVE, dct_pkg::OP_POP:
            begin
                load = hit;
                take = right;
            end
            dct_pkg::OP_INSERT:
            begin
                load = !keep;
                take = keep_left ? op.ent : left;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        valid_next = load ? take.valid    : valid_reg;
        slot_next  = load ? take.slot     : slot_reg;
        dl_next    = load ? take.deadline : dl_reg;
        per_next   = load ? take.period   : per_reg;
    end

    // Valid bit is control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload.
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        dl_reg   <= dl_next;
        per_reg  <= per_next;
    end

endmodule

// ----- src/dct_row.sv -----
// ----------------------------------------------------------------------------
// Deadline callout timer cell row
// A chain of cells holding armed slots in ascending deadline order.
// ----------------------------------------------------------------------------
module dct_row (
    input  logic              clk,
    input  logic              rst_n,
    input  dct_pkg::cell_op_t op,
    output dct_pkg::entry_t   head
);

    dct_pkg::entry_t ents  [dct_pkg::SLOTS+1];
    logic            keeps [dct_pkg::SLOTS+1];
    logic            hits  [dct_pkg::SLOTS+1];

    // Chain boundaries: nothing beyond the tail, and a pop removes the head.
    assign ents[dct_pkg::SLOTS] = '0;
    assign keeps[0]             = 1'b1;
    assign hits[0]              = (op.code == dct_pkg::OP_POP);

    genvar i;
    generate
        for (i = 0; i < dct_pkg::SLOTS; i++)
        begin : g_cell
            dct_pkg::entry_t left_ent;
            dct_pkg::entry_t ent_out;
            if (i == 0)
            begin : g_first
                assign left_ent = '0;
            end
            else
            begin : g_rest
                assign left_ent = ents[i-1];
            end
            dct_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op),
                .left      (left_ent),
                .right     (ents[i+1]),
                .keep_left (keeps[i]),
                .hit_left  (hits[i]),
                .ent       (ent_out),
                .keep      (keeps[i+1]),
                .hit       (hits[i+1])
            );
            assign ents[i] = ent_out;
        end
    endgenerate

    assign head = ents[0];

endmodule

// ----- src/deadline_callout_timer_top.sv -----
// ----------------------------------------------------------------------------
// Deadline callout timer top level
// Sorted timer queue with service, periodic re-arm and latency histogram.
// ----------------------------------------------------------------------------
// An arm runs REMOVE, INSERT, RESCHED on a new head, then EMIT; a cancel or zero-deadline
// arm runs REMOVE then EMIT; an idle service goes to EMIT; a firing service ends in k strobes.
// One item at a time; start is taken again once busy falls.
// When firing, SVC runs, then FIRE pops each due head, REINS re-arms a periodic one, then RESCHED.
// Reset clears the queue, compare value, histogram and sets lead registers.
// Results cannot be stalled; each strobe lasts exactly one cycle.
module deadline_callout_timer_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dct_pkg::item_t   item,
    output logic             strobe,
    output dct_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_REMOVE  = 3'd1;
    localparam logic [2:0] ST_INSERT  = 3'd2;
    localparam logic [2:0] ST_SVC     = 3'd3;
    localparam logic [2:0] ST_FIRE    = 3'd4;
    localparam logic [2:0] ST_REINS   = 3'd5;
    localparam logic [2:0] ST_RESCHED = 3'd6;
    localparam logic [2:0] ST_EMIT    = 3'd7;

    logic [2:0]                   state_reg;
    logic                         busy_reg;
    logic                         strobe_reg;
    dct_pkg::result_t             result_reg;
    logic [19:0]                  min_lead_reg;
    logic [31:0]                  max_lead_reg;
    logic [63:0]                  compare_reg;
    logic [31:0]                  cnt_reg [dct_pkg::BUCKETS+1];
    logic [dct_pkg::BUCKET_W-1:0] bucket_reg;
    logic [31:0]                  count_reg;
    logic [dct_pkg::FIRE_W-1:0]   nf_reg;
    logic [dct_pkg::FIDX_W-1:0]   rd_ptr_reg;
    logic [2:0]                   kind_reg;
    logic [dct_pkg::SLOT_W-1:0]   slot_reg;
    logic [63:0]                  now_reg, d_reg, p_reg, lo_reg, hi_reg;
    logic [15:0]                  lat_reg;
    logic [dct_pkg::SLOT_W+63:0]  fire_mem [dct_pkg::MAX_FIRE];
    logic [dct_pkg::SLOT_W+63:0]  mem_q_reg;

    dct_pkg::cell_op_t            op;
    dct_pkg::entry_t              head;
    logic                         accept;
    logic                         svc_act;
    logic [63:0]                  arm_d;
    logic                         fire_now;
    logic [dct_pkg::BUCKET_W-1:0] bkt;
    logic [31:0]                  cnt_inc;
    logic [63:0]                  c_new;
    logic                         emit_last;

    assign busy      = busy_reg;
    assign strobe    = strobe_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy_reg;

    dct_row u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .head  (head)
    );

    // Item decode at accept.
    always_comb
    begin
        svc_act = (item.kind == dct_pkg::KIND_SERVICE) && (compare_reg != 64'd0)
                  && (item.now >= compare_reg);
        unique case (item.kind)
            dct_pkg::KIND_ARM_AT: arm_d = item.when;
            default:              arm_d = dct_pkg::sat_add(item.now, item.when);
        endcase
    end

    // Fire condition, histogram update and compare recomputation.
    always_comb
    begin
        fire_now = (nf_reg < dct_pkg::FIRE_W'(dct_pkg::MAX_FIRE)) && head.valid
                   && (head.deadline <= now_reg);
        bkt      = dct_pkg::bucket_of(lat_reg);
        cnt_inc  = cnt_reg[bkt] + 32'd1;
        if (!head.valid)
        begin
            c_new = hi_reg;
        end
        else if (head.deadline <= lo_reg)
        begin
            c_new = lo_reg;
        end
        else if (head.deadline < hi_reg)
        begin
            c_new = head.deadline;
        end
        else
        begin
            c_new = hi_reg;
        end
        emit_last = (nf_reg == dct_pkg::FIRE_W'(0))
                    || ({1'b0, rd_ptr_reg} == nf_reg - dct_pkg::FIRE_W'(1));
    end

    // Operation sent to the cell row.
    always_comb
    begin
        op           = '0;
        op.ent.valid = 1'b1;
        op.ent.slot  = slot_reg;
        op.ent.deadline = d_reg;
        op.ent.period   = p_reg;
        unique case (state_reg)
            ST_REMOVE:                op.code = dct_pkg::OP_REMOVE;
            ST_INSERT, ST_REINS:      op.code = dct_pkg::OP_INSERT;
            ST_FIRE:                  op.code = fire_now ? dct_pkg::OP_POP : dct_pkg::OP_NONE;
            default:                  op.code = dct_pkg::OP_NONE;
        endcase
    end

    // Fired-slot buffer and its registered read port.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIRE && fire_now)
        begin
            fire_mem[nf_reg[dct_pkg::FIDX_W-1:0]] <= {head.slot, head.deadline};
        end
        if (state_reg == ST_RESCHED)
        begin
            mem_q_reg <= fire_mem[0];
        end
        else if (state_reg == ST_EMIT)
        begin
            mem_q_reg <= fire_mem[rd_ptr_reg + dct_pkg::FIDX_W'(1)];
        end
    end

    // Item payload captured at accept; slot, deadline and period are reloaded from each fired head.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= item.kind;
            now_reg  <= item.now;
            lat_reg  <= item.now[15:0] - compare_reg[15:0];
            lo_reg   <= dct_pkg::sat_add(item.now,
                            (min_lead_reg == 20'd0) ? 64'd1 : {44'd0, min_lead_reg});
            hi_reg   <= dct_pkg::sat_add(item.now,
                            (max_lead_reg == 32'd0) ? 64'd1 : {32'd0, max_lead_reg});
            slot_reg <= item.slot;
            d_reg    <= arm_d;
            p_reg    <= (item.kind == dct_pkg::KIND_ARM_EVERY) ? item.period : 64'd0;
        end
        else if (state_reg == ST_FIRE && fire_now)
        begin
            slot_reg <= head.slot;
            d_reg    <= dct_pkg::sat_add(head.deadline, head.period);
            p_reg    <= head.period;
        end
    end

    // Control sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            busy_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
            result_reg   <= '0;
            min_lead_reg <= dct_pkg::MIN_LEAD_RESET;
            max_lead_reg <= dct_pkg::MAX_LEAD_RESET;
            compare_reg  <= 64'd0;
            for (int i = 0; i <= dct_pkg::BUCKETS; i++)
            begin
                cnt_reg[i] <= 32'd0;
            end
            bucket_reg   <= '0;
            count_reg    <= 32'd0;
            nf_reg       <= '0;
            rd_ptr_reg   <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;

            // Configuration writes.
            if (cfg_valid)
            begin
                if (cfg_index == dct_pkg::REG_MIN_LEAD)
                begin
                    min_lead_reg <= cfg_data[19:0];
                end
                else if (cfg_index == dct_pkg::REG_MAX_LEAD)
                begin
                    max_lead_reg <= cfg_data;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        busy_reg   <= 1'b1;
                        nf_reg     <= '0;
                        rd_ptr_reg <= '0;
                        bucket_reg <= '0;
                        count_reg  <= 32'd0;
                        if (item.kind <= dct_pkg::KIND_CANCEL)
                        begin
                            state_reg <= ST_REMOVE;
                        end
                        else if (svc_act)
                        begin
                            state_reg <= ST_SVC;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_REMOVE:
                begin
                    if (kind_reg != dct_pkg::KIND_CANCEL && d_reg != 64'd0)
                    begin
                        state_reg <= ST_INSERT;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_INSERT:
                begin
                    if (!head.valid || d_reg < head.deadline)
                    begin
                        state_reg <= ST_RESCHED;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_SVC:
                begin
                    cnt_reg[bkt] <= cnt_inc;
                    bucket_reg   <= bkt;
                    count_reg    <= cnt_inc;
                    state_reg    <= ST_FIRE;
                end
                ST_FIRE:
                begin
                    if (fire_now)
                    begin
                        nf_reg <= nf_reg + dct_pkg::FIRE_W'(1);
                        if (head.period != 64'd0)
                        begin
                            state_reg <= ST_REINS;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_RESCHED;
                    end
                end
                ST_REINS:
                begin
                    state_reg <= ST_FIRE;
                end
                ST_RESCHED:
                begin
                    compare_reg <= c_new;
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    strobe_reg                <= 1'b1;
                    result_reg.next_compare   <= compare_reg;
                    result_reg.latency_bucket <= bucket_reg;
                    result_reg.latency_count  <= count_reg;
                    result_reg.last           <= emit_last;
                    if (nf_reg == dct_pkg::FIRE_W'(0))
                    begin
                        result_reg.fired      <= 1'b0;
                        result_reg.fired_slot <= '0;
                        result_reg.due_time   <= 64'd0;
                    end
                    else
                    begin
                        result_reg.fired      <= 1'b1;
                        result_reg.fired_slot <= mem_q_reg[dct_pkg::SLOT_W+63:64];
                        result_reg.due_time   <= mem_q_reg[63:0];
                    end
                    rd_ptr_reg <= rd_ptr_reg + dct_pkg::FIDX_W'(1);
                    if (emit_last)
                    begin
                        busy_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/dct_checker.sv -----
// ----------------------------------------------------------------------------
// Deadline callout timer port checker
// Watches the top-level ports for transaction ordering rules.
// ----------------------------------------------------------------------------
module dct_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             strobe,
    input dct_pkg::result_t result
);

    // An accepted transaction keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after accept");

    // Only the final result of a transaction may show while idle.
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("non-final result while idle");

    // A result that reports no fire is always the only one.
    a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.fired |-> result.last)
        else $error("non-fire result not final");

    // A non-fire result carries no slot and no deadline.
    a_nofire_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.fired |-> result.fired_slot == 4'd0 && result.due_time == 64'd0)
        else $error("non-fire result carries slot data");

endmodule

bind deadline_callout_timer_top dct_checker u_dct_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Deadline callout timer testbench
// Drives timer commands and services with random gaps and checks every
// result strobe against a sorted-queue predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 200;

    // Kinds outside the defined set, used to check that they change nothing.
    localparam logic [2:0] KIND_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN_LAST  = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    dct_pkg::item_t   item;
    logic             strobe;
    dct_pkg::result_t result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [31:0]      cfg_data;

    int idle_pct;

    deadline_callout_timer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor of the timer queue and queue of expected result transactions.
    class timer_scoreboard;
        logic [63:0]      deadline [dct_pkg::SLOTS];
        logic [63:0]      period [dct_pkg::SLOTS];
        logic [3:0]       order [$];
        logic [63:0]      compare;
        logic [31:0]      hist [dct_pkg::BUCKETS+1];
        logic [19:0]      min_lead;
        logic [31:0]      max_lead;
        dct_pkg::result_t pending [$];
        int               mismatches;

        function void clear();
            for (int i = 0; i < dct_pkg::SLOTS; i++)
            begin
                deadline[i] = '0;
                period[i] = '0;
            end
            for (int i = 0; i <= dct_pkg::BUCKETS; i++)
            begin
                hist[i] = '0;
            end
            order = {};
            pending = {};
            compare = '0;
            min_lead = dct_pkg::MIN_LEAD_RESET;
            max_lead = dct_pkg::MAX_LEAD_RESET;
            mismatches = 0;
        endfunction

        function logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? {64{1'b1}} : s[63:0];
        endfunction

        function void drop_slot(logic [3:0] s);
            for (int i = 0; i < order.size(); i++)
            begin
                if (order[i] == s)
                begin
                    order.delete(i);
                    return;
                end
            end
        endfunction

        // Later arrivals go behind equal deadlines; returns 1 on a new head.
        function bit enqueue(logic [3:0] s);
            int pos;
            pos = 0;
            while (pos < order.size() && deadline[order[pos]] <= deadline[s])
            begin
                pos++;
            end
            order.insert(pos, s);
            return pos == 0;
        endfunction

        function void recompute(logic [63:0] now);
            logic [63:0] lo;
            logic [63:0] c;
            logic [63:0] h;
            lo = sum_sat(now, (min_lead == 0) ? 64'd1 : 64'(min_lead));
            c = sum_sat(now, (max_lead == 0) ? 64'd1 : 64'(max_lead));
            if (order.size() > 0)
            begin
                h = deadline[order[0]];
                if (h <= lo)
                begin
                    c = lo;
                end
                else if (h < c)
                begin
                    c = h;
                end
            end
            compare = c;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == dct_pkg::REG_MIN_LEAD)
            begin
                min_lead = data[19:0];
            end
            else if (idx == dct_pkg::REG_MAX_LEAD)
            begin
                max_lead = data;
            end
        endfunction

        // Notes one accepted command transaction and queues its results.
        function void note_item(dct_pkg::item_t it);
            logic [63:0]      d;
            logic [63:0]      p;
            logic [15:0]      lat;
            logic [3:0]       bkt;
            logic [3:0]       h;
            logic [3:0]       fs [$];
            logic [63:0]      fd [$];
            dct_pkg::result_t r;
            d = '0;
            p = '0;
            r = '0;
            if (it.kind <= dct_pkg::KIND_CANCEL)
            begin
                if (deadline[it.slot] != 0)
                begin
                    drop_slot(it.slot);
                end
                if (it.kind == dct_pkg::KIND_ARM_AT)
                begin
                    d = it.when;
                end
                else if (it.kind == dct_pkg::KIND_ARM_AFTER)
                begin
                    d = sum_sat(it.now, it.when);
                end
                else if (it.kind == dct_pkg::KIND_ARM_EVERY)
                begin
                    d = sum_sat(it.now, it.when);
                    p = it.period;
                end
                if (it.kind == dct_pkg::KIND_CANCEL || d == 0)
                begin
                    deadline[it.slot] = '0;
                    period[it.slot] = '0;
                end
                else
                begin
                    deadline[it.slot] = d;
                    period[it.slot] = p;
                    if (enqueue(it.slot))
                    begin
                        recompute(it.now);
                    end
                end
            end
            else if (it.kind == dct_pkg::KIND_SERVICE && compare != 0 && it.now >= compare)
            begin
                lat = 16'(it.now - compare);
                bkt = '0;
                while (bkt < dct_pkg::BUCKETS && lat > dct_pkg::BOUND[bkt])
                begin
                    bkt++;
                end
                hist[bkt]++;
                while (fs.size() < dct_pkg::MAX_FIRE && order.size() > 0)
                begin
                    h = order[0];
                    if (deadline[h] > it.now)
                    begin
                        break;
                    end
                    order.delete(0);
                    fs.push_back(h);
                    fd.push_back(deadline[h]);
                    deadline[h] = '0;
                    if (period[h] != 0)
                    begin
                        deadline[h] = sum_sat(fd[fd.size()-1], period[h]);
                        void'(enqueue(h));
                    end
                end
                recompute(it.now);
                r.next_compare = compare;
                r.latency_bucket = bkt;
                r.latency_count = hist[bkt];
                for (int k = 0; k < fs.size(); k++)
                begin
                    r.fired = 1'b1;
                    r.fired_slot = fs[k];
                    r.due_time = fd[k];
                    r.last = (k == fs.size() - 1);
                    pending.push_back(r);
                end
                if (fs.size() == 0)
                begin
                    r.last = 1'b1;
                    pending.push_back(r);
                end
                return;
            end
            r.next_compare = compare;
            r.last = 1'b1;
            pending.push_back(r);
        endfunction

        // Compares one result transaction with the oldest expectation.
        function void check_result(dct_pkg::result_t got);
            dct_pkg::result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: unexpected result %h", got);
                end
                return;
            end
            want = pending.pop_front();
            if (got.fired !== want.fired || got.fired_slot !== want.fired_slot ||
                got.due_time !== want.due_time ||
                got.next_compare !== want.next_compare ||
                got.latency_bucket !== want.latency_bucket ||
                got.latency_count !== want.latency_count || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result mismatch expected %h got %h", want, got);
                end
            end
        endfunction
    endclass

    timer_scoreboard timer_sb;
    int  stall_cycles;
    bit  timed_out;
    logic [63:0] sim_now;

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result monitor and watchdog on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
            begin
                timer_sb.check_result(result);
            end
            if (strobe || (start && !busy) || (cfg_valid && cfg_ready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= WATCHDOG_LIMIT && !timed_out)
            begin
                timed_out = 1'b1;
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Sends one command transaction, with a random gap before it.
    // Start stays high after the accept until the next call decides.
    task automatic send_item(dct_pkg::item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            item <= '0;
            @(negedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        timer_sb.note_item(it);
        @(negedge clk);
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic drain();
        start <= 1'b0;
        item <= '0;
        while (timer_sb.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        timer_sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly well-formed: times near the running clock, services that catch up.
    task automatic random_item();
        dct_pkg::item_t it;
        int             sel;
        it = '0;
        sel = $urandom_range(99);
        it.slot = 4'($urandom_range(dct_pkg::SLOTS - 1));
        sim_now = sim_now + 64'($urandom_range(40));
        it.now = sim_now;
        if (sel < 35)
        begin
            it.kind = dct_pkg::KIND_SERVICE;
            if ($urandom_range(3) == 0)
            begin
                sim_now = sim_now + 64'($urandom_range(1500));
            end
            if (timer_sb.compare > sim_now && $urandom_range(1) == 0 &&
                timer_sb.compare - sim_now < 64'd3000)
            begin
                sim_now = timer_sb.compare + 64'($urandom_range(1200));
            end
            it.now = sim_now;
        end
        else if (sel < 55)
        begin
            it.kind = dct_pkg::KIND_ARM_AFTER;
            it.when = 64'($urandom_range(300));
        end
        else if (sel < 70)
        begin
            it.kind = dct_pkg::KIND_ARM_EVERY;
            it.when = 64'($urandom_range(200));
            it.period = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(150));
        end
        else if (sel < 82)
        begin
            it.kind = dct_pkg::KIND_ARM_AT;
            it.when = ($urandom_range(9) == 0) ? rand64()
                      : sim_now + 64'($urandom_range(400));
        end
        else if (sel < 92)
        begin
            it.kind = dct_pkg::KIND_CANCEL;
        end
        else
        begin
            // Noise: any kind and any field values.
            it.kind = 3'($urandom_range(7));
            it.now = rand64();
            it.when = rand64();
            it.period = rand64();
        end
        if ($urandom_range(19) == 0)
        begin
            it.period = rand64();
        end
        send_item(it);
    endtask

    task automatic make_item(logic [2:0] k, logic [3:0] s, logic [63:0] n,
                             logic [63:0] w, logic [63:0] p);
        dct_pkg::item_t it;
        it.kind = k;
        it.slot = s;
        it.now = n;
        it.when = w;
        it.period = p;
        send_item(it);
    endtask

    initial
    begin
        timer_sb = new();
        timer_sb.clear();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = dct_pkg::REG_MIN_LEAD;
        cfg_data = '0;
        stall_cycles = 0;
        timed_out = 1'b0;
        idle_pct = 8;
        sim_now = 64'd1000;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: service on empty queue, every kind, ties, zero deadline.
        make_item(dct_pkg::KIND_SERVICE, 4'd0, 64'd0, 64'd0, 64'd0);
        make_item(dct_pkg::KIND_ARM_AT, 4'd3, 64'd100, 64'd500, 64'd0);
        make_item(dct_pkg::KIND_ARM_AT, 4'd5, 64'd100, 64'd500, 64'd0);
        make_item(dct_pkg::KIND_ARM_AT, 4'd15, 64'd100, 64'd500, {64{1'b1}});
        make_item(dct_pkg::KIND_ARM_AFTER, 4'd0, 64'd100, 64'd200, 64'd0);
        make_item(dct_pkg::KIND_ARM_EVERY, 4'd7, 64'd100, 64'd50, 64'd100);
        make_item(dct_pkg::KIND_ARM_AT, 4'd9, 64'd100, 64'd0, 64'd0);
        make_item(dct_pkg::KIND_CANCEL, 4'd5, 64'd100, 64'd0, 64'd0);
        make_item(dct_pkg::KIND_SERVICE, 4'd0, 64'd140, 64'd0, 64'd0);
        make_item(dct_pkg::KIND_SERVICE, 4'd0, 64'd151, 64'd0, 64'd0);
        make_item(dct_pkg::KIND_SERVICE, 4'd0, 64'd600, 64'd0, 64'd0);
        make_item(dct_pkg::KIND_ARM_AFTER, 4'd1, {64{1'b1}}, {64{1'b1}}, 64'd0);
        make_item(dct_pkg::KIND_ARM_EVERY, 4'd2, 64'd700, 64'd5, {64{1'b1}});
        make_item(KIND_UNKNOWN_FIRST, 4'd2, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
        make_item(KIND_UNKNOWN_LAST, 4'd15, 64'd0, 64'd0, 64'd0);
        make_item(dct_pkg::KIND_SERVICE, 4'd0, 64'd40000, 64'd0, 64'd0);
        make_item(dct_pkg::KIND_SERVICE, 4'd0, {64{1'b1}}, 64'd0, 64'd0);
        make_item(dct_pkg::KIND_CANCEL, 4'd1, 64'd0, 64'd0, 64'd0);
        make_item(dct_pkg::KIND_CANCEL, 4'd7, 64'd0, 64'd0, 64'd0);
        make_item(dct_pkg::KIND_CANCEL, 4'd2, 64'd0, 64'd0, 64'd0);
        drain();

        // Random phases across lead settings, extremes among them.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(dct_pkg::REG_MIN_LEAD, 32'd1);
                    write_reg(dct_pkg::REG_MAX_LEAD, 32'd1000);
                end
                1:
                begin
                    write_reg(dct_pkg::REG_MIN_LEAD, 32'd0);
                    write_reg(dct_pkg::REG_MAX_LEAD, 32'd0);
                end
                2:
                begin
                    write_reg(dct_pkg::REG_MIN_LEAD, 32'hFFFFF);
                    write_reg(dct_pkg::REG_MAX_LEAD, 32'hFFFFFFFF);
                end
                3:
                begin
                    write_reg(dct_pkg::REG_MIN_LEAD, 32'd50);
                    write_reg(dct_pkg::REG_MAX_LEAD, 32'd300);
                end
                default:
                begin
                    write_reg(dct_pkg::REG_MIN_LEAD, $urandom());
                    write_reg(dct_pkg::REG_MAX_LEAD, $urandom());
                end
            endcase
            idle_pct = (ph < 2) ? 8 : ((ph < 4) ? 88 : 0);
            if (ph == 2)
            begin
                // Large leads: keep time moving past the compare value.
                sim_now = sim_now + 64'd2000000;
            end
            for (int n = 0; n < 34; n++)
            begin
                random_item();
            end
            drain();
        end

        if (timer_sb.mismatches == 0 && timer_sb.pending.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
